[hdl/pdist_pkg.sv]
// Shared types and constants of the polyline point-at-distance block.
`default_nettype none
package pdist_pkg;

   localparam int MAX_POINTS_DEF  = 64;
   localparam int COORD_WIDTH_DEF = 32;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_SQRT = 2'd1,
      OP_DIV  = 2'd2
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
      logic   clear_acc;
   } unit_ctl_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_FIRST_RD,
      S_FIRST_CAP,
      S_LEN_RDA,
      S_LEN_RDB,
      S_LEN_CAP,
      S_LEN_MX,
      S_LEN_MY,
      S_LEN_MZ,
      S_LEN_SQ,
      S_CHECK,
      S_MOD_LD,
      S_MOD_DIV,
      S_WALK_RD,
      S_WALK_CAP,
      S_INT_RDA,
      S_INT_RDB,
      S_INT_CAP,
      S_INT_MX,
      S_INT_DX,
      S_INT_MY,
      S_INT_DY,
      S_INT_MZ,
      S_INT_DZ,
      S_RSP
   } state_type;

endpackage
`default_nettype wire

[hdl/pdist_unit.sv]
// Shared bit-serial unit: multiply-accumulate, integer square root and division.
`default_nettype none
module pdist_unit
   import pdist_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int MAX_POINTS  = MAX_POINTS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire unit_ctl_type          ctl,
   input  wire logic [2*COORD_WIDTH+1:0] opa,
   input  wire logic [COORD_WIDTH:0]  opb,
   input  wire logic [COORD_WIDTH+$clog2(MAX_POINTS):0] divisor,
   output logic                       done,
   output logic [2*COORD_WIDTH+1:0]   quot,
   output logic [COORD_WIDTH:0]       root,
   output logic [COORD_WIDTH+$clog2(MAX_POINTS):0] rem
);

   localparam int BW = COORD_WIDTH + 1;
   localparam int NW = 2 * BW;
   localparam int TW = BW + $clog2(MAX_POINTS);
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   op_type        op_ff, op_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] acc_ff, acc_in;
   logic [NW-1:0] mcand_ff, mcand_in;
   logic [BW-1:0] mplier_ff, mplier_in;
   logic [BW-1:0] root_ff, root_in;
   logic [BW+2:0] srem_ff, srem_in;
   logic [TW-1:0] drem_ff, drem_in;
   logic [TW-1:0] dvsr_ff, dvsr_in;

   logic [BW+2:0] sq_shift;
   logic [BW+2:0] sq_trial;
   logic [TW:0]   dv_shift;
   logic [TW:0]   dv_diff;

   always_comb begin
      sq_shift = {srem_ff[BW:0], acc_ff[NW-1:NW-2]};
      sq_trial = {1'b0, root_ff, 2'b01};
      dv_shift = {drem_ff, acc_ff[NW-1]};
      dv_diff  = dv_shift - {1'b0, dvsr_ff};

      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      root_in   = root_ff;
      srem_in   = srem_ff;
      drem_in   = drem_ff;
      dvsr_in   = dvsr_ff;

      if (!busy_ff && ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         case (ctl.op)
            OP_MUL: begin
               if (ctl.clear_acc) begin
                  acc_in = '0;
               end
               mcand_in  = opa;
               mplier_in = opb;
               cnt_in    = CW'(BW);
            end
            OP_SQRT: begin
               root_in = '0;
               srem_in = '0;
               cnt_in  = CW'(BW);
            end
            OP_DIV: begin
               drem_in = '0;
               dvsr_in = divisor;
               cnt_in  = CW'(NW);
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         case (op_ff)
            OP_MUL: begin
               if (mplier_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in  = {mcand_ff[NW-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[BW-1:1]};
            end
            OP_SQRT: begin
               acc_in = {acc_ff[NW-3:0], 2'b00};
               if (sq_shift >= sq_trial) begin
                  srem_in = sq_shift - sq_trial;
                  root_in = {root_ff[BW-2:0], 1'b1};
               end else begin
                  srem_in = sq_shift;
                  root_in = {root_ff[BW-2:0], 1'b0};
               end
            end
            OP_DIV: begin
               if (dv_shift >= {1'b0, dvsr_ff}) begin
                  drem_in = dv_diff[TW-1:0];
                  acc_in  = {acc_ff[NW-2:0], 1'b1};
               end else begin
                  drem_in = dv_shift[TW-1:0];
                  acc_in  = {acc_ff[NW-2:0], 1'b0};
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      root_ff   <= root_in;
      srem_ff   <= srem_in;
      drem_ff   <= drem_in;
      dvsr_ff   <= dvsr_in;
   end

   assign done = done_ff;
   assign quot = acc_ff;
   assign root = root_ff;
   assign rem  = drem_ff;

endmodule
`default_nettype wire

[hdl/pdist_store.sv]
// Point memories and segment length memory with registered reads.
`default_nettype none
module pdist_store
   import pdist_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int MAX_POINTS  = MAX_POINTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          pt_we,
   input  wire logic [$clog2(MAX_POINTS)-1:0] pt_waddr,
   input  wire logic [COORD_WIDTH-1:0]        wr_x,
   input  wire logic [COORD_WIDTH-1:0]        wr_y,
   input  wire logic [COORD_WIDTH-1:0]        wr_z,
   input  wire logic [$clog2(MAX_POINTS)-1:0] pt_raddr,
   output logic [COORD_WIDTH-1:0]             rd_x,
   output logic [COORD_WIDTH-1:0]             rd_y,
   output logic [COORD_WIDTH-1:0]             rd_z,
   input  wire logic                          len_we,
   input  wire logic [$clog2(MAX_POINTS)-1:0] len_waddr,
   input  wire logic [COORD_WIDTH:0]          len_wdata,
   input  wire logic [$clog2(MAX_POINTS)-1:0] len_raddr,
   output logic [COORD_WIDTH:0]               len_rdata
);

   logic [COORD_WIDTH-1:0] mem_x_ff [MAX_POINTS];
   logic [COORD_WIDTH-1:0] mem_y_ff [MAX_POINTS];
   logic [COORD_WIDTH-1:0] mem_z_ff [MAX_POINTS];
   logic [COORD_WIDTH:0]   mem_len_ff [MAX_POINTS];

   logic [COORD_WIDTH-1:0] rd_x_ff, rd_y_ff, rd_z_ff;
   logic [COORD_WIDTH:0]   len_rd_ff;

   always_ff @(posedge clock) begin
      if (pt_we) begin
         mem_x_ff[pt_waddr] <= wr_x;
         mem_y_ff[pt_waddr] <= wr_y;
         mem_z_ff[pt_waddr] <= wr_z;
      end
      rd_x_ff <= mem_x_ff[pt_raddr];
      rd_y_ff <= mem_y_ff[pt_raddr];
      rd_z_ff <= mem_z_ff[pt_raddr];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         mem_len_ff[len_waddr] <= len_wdata;
      end
      len_rd_ff <= mem_len_ff[len_raddr];
   end

   assign rd_x      = rd_x_ff;
   assign rd_y      = rd_y_ff;
   assign rd_z      = rd_z_ff;
   assign len_rdata = len_rd_ff;

endmodule
`default_nettype wire

[hdl/polyline_point_at_distance.sv]
// Top level: polyline store and the sequencer that answers arc-length queries.
//
// Each request transaction carries a command: append a point, clear the path,
// query the point at an arc length, or do nothing. Every request transaction
// yields exactly one response transaction with a position and a status.
// The block takes one request at a time; req_stall is high from acceptance
// until the response has been taken.
// Append, clear and no-operation responses are valid in the cycle right after
// acceptance. A query on N points first measures every segment with the
// shared bit-serial unit: three squaring passes and one root of
// (COORD_WIDTH+1) steps each. A wrap of the distance adds a division,
// the walk then steps through the segments in turn, and interpolation
// adds a multiply and a divide per axis. The shared unit does one step
// of one operation a cycle. Reset empties the path; stored coordinates
// are not cleared and are never read before written. While rsp_stall is
// high the response holds steady.
`default_nettype none
module polyline_point_at_distance
   import pdist_pkg::*;
#(
   parameter int MAX_POINTS  = MAX_POINTS_DEF,
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_cmd,
   input  wire logic [COORD_WIDTH-1:0] req_point_x,
   input  wire logic [COORD_WIDTH-1:0] req_point_y,
   input  wire logic [COORD_WIDTH-1:0] req_point_z,
   input  wire logic [31:0]            req_query_distance,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [COORD_WIDTH-1:0]      rsp_pos_x,
   output logic [COORD_WIDTH-1:0]      rsp_pos_y,
   output logic [COORD_WIDTH-1:0]      rsp_pos_z,
   output logic [1:0]                  rsp_status
);

   localparam int C    = COORD_WIDTH;
   localparam int BW   = C + 1;
   localparam int NW   = 2 * BW;
   localparam int AW   = $clog2(MAX_POINTS);
   localparam int TW   = BW + AW;
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int DW   = (TW > 32) ? TW : 32;

   state_type     state_ff, state_in;
   logic          launch_ff, launch_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [AW-1:0] seg_ff, seg_in;
   logic [DW-1:0] d_ff, d_in;
   logic [TW-1:0] total_ff, total_in;
   logic [TW-1:0] start_ff, start_in;
   logic [BW-1:0] len_ff, len_in;
   logic [BW-1:0] t_ff, t_in;
   logic [C-1:0]  cur_x_ff, cur_y_ff, cur_z_ff, cur_x_in, cur_y_in, cur_z_in;
   logic [C:0]    dl_x_ff, dl_y_ff, dl_z_ff, dl_x_in, dl_y_in, dl_z_in;
   logic [C-1:0]  pos_x_ff, pos_y_ff, pos_z_ff, pos_x_in, pos_y_in, pos_z_in;
   logic [1:0]    status_ff, status_in;

   // Shared unit and memory hookup.
   unit_ctl_type  ctl;
   logic [NW-1:0] u_opa;
   logic [BW-1:0] u_opb;
   logic [TW-1:0] u_divisor;
   logic          u_done;
   logic [NW-1:0] u_quot;
   logic [BW-1:0] u_root;
   logic [TW-1:0] u_rem;

   logic          pt_we;
   logic [AW-1:0] pt_raddr;
   logic [C-1:0]  rd_x, rd_y, rd_z;
   logic          len_we;
   logic [BW-1:0] len_rdata;

   logic          req_acc;
   logic          last_seg;
   logic          full;
   logic [BW-1:0] mag_x, mag_y, mag_z;
   logic [DW-1:0] walk_diff;
   logic [C-1:0]  q_low;
   cmd_type       cmd;

   assign cmd       = cmd_type'(req_cmd);
   assign req_acc   = req_valid && !req_stall;
   assign full      = (count_ff == CNTW'(MAX_POINTS));
   assign last_seg  = ((CNTW'(seg_ff) + CNTW'(2)) == count_ff);
   assign walk_diff = d_ff - DW'(start_ff);
   assign q_low     = u_quot[C-1:0];

   // Magnitudes of the signed segment deltas; the most negative delta
   // still fits because the magnitude is kept one bit wider than a coordinate.
   assign mag_x = dl_x_ff[C] ? (~dl_x_ff + BW'(1)) : dl_x_ff;
   assign mag_y = dl_y_ff[C] ? (~dl_y_ff + BW'(1)) : dl_y_ff;
   assign mag_z = dl_z_ff[C] ? (~dl_z_ff + BW'(1)) : dl_z_ff;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (cmd == CMD_QUERY && count_ff != '0) begin
                  state_in = S_FIRST_RD;
               end else begin
                  state_in = S_RSP;
               end
            end
         end
         S_FIRST_RD:  state_in = S_FIRST_CAP;
         S_FIRST_CAP: state_in = (count_ff == CNTW'(1)) ? S_RSP : S_LEN_RDA;
         S_LEN_RDA:   state_in = S_LEN_RDB;
         S_LEN_RDB:   state_in = S_LEN_CAP;
         S_LEN_CAP:   state_in = S_LEN_MX;
         S_LEN_MX:    if (u_done) state_in = S_LEN_MY;
         S_LEN_MY:    if (u_done) state_in = S_LEN_MZ;
         S_LEN_MZ:    if (u_done) state_in = S_LEN_SQ;
         S_LEN_SQ: begin
            if (u_done) begin
               state_in = last_seg ? S_CHECK : S_LEN_RDA;
            end
         end
         S_CHECK: begin
            if (total_ff == '0) begin
               state_in = S_RSP;
            end else if (d_ff > DW'(total_ff)) begin
               state_in = S_MOD_LD;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_MOD_LD:    if (u_done) state_in = S_MOD_DIV;
         S_MOD_DIV:   if (u_done) state_in = S_WALK_RD;
         S_WALK_RD:   state_in = S_WALK_CAP;
         S_WALK_CAP: begin
            if (walk_diff < DW'(len_rdata)) begin
               state_in = S_INT_RDA;
            end else begin
               state_in = last_seg ? S_RSP : S_WALK_RD;
            end
         end
         S_INT_RDA:   state_in = S_INT_RDB;
         S_INT_RDB:   state_in = S_INT_CAP;
         S_INT_CAP:   state_in = S_INT_MX;
         S_INT_MX:    if (u_done) state_in = S_INT_DX;
         S_INT_DX:    if (u_done) state_in = S_INT_MY;
         S_INT_MY:    if (u_done) state_in = S_INT_DY;
         S_INT_DY:    if (u_done) state_in = S_INT_MZ;
         S_INT_MZ:    if (u_done) state_in = S_INT_DZ;
         S_INT_DZ:    if (u_done) state_in = S_RSP;
         S_RSP:       if (!rsp_stall) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Control outputs: handshakes, unit commands and memory addresses.
   always_comb begin
      req_stall     = (state_ff != S_IDLE);
      rsp_valid     = (state_ff == S_RSP);
      ctl.start     = 1'b0;
      ctl.op        = OP_MUL;
      ctl.clear_acc = 1'b0;
      u_opa         = NW'(mag_x);
      u_opb         = mag_x;
      u_divisor     = TW'(len_ff);
      pt_raddr      = seg_ff;
      pt_we         = 1'b0;
      len_we        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            pt_we = req_acc && (cmd == CMD_APPEND) && !full;
         end
         S_FIRST_RD: pt_raddr = '0;
         S_LEN_RDB:  pt_raddr = seg_ff + AW'(1);
         S_INT_RDB:  pt_raddr = seg_ff + AW'(1);
         S_LEN_MX: begin
            ctl.start     = launch_ff;
            ctl.clear_acc = 1'b1;
         end
         S_LEN_MY: begin
            ctl.start = launch_ff;
            u_opa     = NW'(mag_y);
            u_opb     = mag_y;
         end
         S_LEN_MZ: begin
            ctl.start = launch_ff;
            u_opa     = NW'(mag_z);
            u_opb     = mag_z;
         end
         S_LEN_SQ: begin
            ctl.start = launch_ff;
            ctl.op    = OP_SQRT;
            len_we    = u_done;
         end
         S_MOD_LD: begin
            ctl.start     = launch_ff;
            ctl.clear_acc = 1'b1;
            u_opa         = NW'(d_ff);
            u_opb         = BW'(1);
         end
         S_MOD_DIV: begin
            ctl.start = launch_ff;
            ctl.op    = OP_DIV;
            u_divisor = total_ff;
         end
         S_INT_MX: begin
            ctl.start     = launch_ff;
            ctl.clear_acc = 1'b1;
            u_opb         = t_ff;
         end
         S_INT_MY: begin
            ctl.start     = launch_ff;
            ctl.clear_acc = 1'b1;
            u_opa         = NW'(mag_y);
            u_opb         = t_ff;
         end
         S_INT_MZ: begin
            ctl.start     = launch_ff;
            ctl.clear_acc = 1'b1;
            u_opa         = NW'(mag_z);
            u_opb         = t_ff;
         end
         S_INT_DX, S_INT_DY, S_INT_DZ: begin
            ctl.start = launch_ff;
            ctl.op    = OP_DIV;
         end
         default: begin
            pt_raddr = seg_ff;
         end
      endcase
   end

   // Datapath registers, updated per state.
   always_comb begin
      launch_in = (state_in != state_ff);
      count_in  = count_ff;
      seg_in    = seg_ff;
      d_in      = d_ff;
      total_in  = total_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      t_in      = t_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      cur_z_in  = cur_z_ff;
      dl_x_in   = dl_x_ff;
      dl_y_in   = dl_y_ff;
      dl_z_in   = dl_z_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      pos_z_in  = pos_z_ff;
      status_in = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               pos_x_in  = '0;
               pos_y_in  = '0;
               pos_z_in  = '0;
               status_in = STATUS_OK;
               d_in      = DW'(req_query_distance);
               case (cmd)
                  CMD_APPEND: begin
                     if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        count_in = count_ff + CNTW'(1);
                     end
                  end
                  CMD_CLEAR: count_in = '0;
                  CMD_QUERY: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         S_FIRST_CAP: begin
            // The first point is the answer unless a segment holds the distance.
            pos_x_in = rd_x;
            pos_y_in = rd_y;
            pos_z_in = rd_z;
            total_in = '0;
            seg_in   = '0;
         end
         S_LEN_RDB, S_INT_RDB: begin
            cur_x_in = rd_x;
            cur_y_in = rd_y;
            cur_z_in = rd_z;
         end
         S_LEN_CAP, S_INT_CAP: begin
            dl_x_in = {rd_x[C-1], rd_x} - {cur_x_ff[C-1], cur_x_ff};
            dl_y_in = {rd_y[C-1], rd_y} - {cur_y_ff[C-1], cur_y_ff};
            dl_z_in = {rd_z[C-1], rd_z} - {cur_z_ff[C-1], cur_z_ff};
         end
         S_LEN_SQ: begin
            if (u_done) begin
               total_in = total_ff + TW'(u_root);
               if (!last_seg) begin
                  seg_in = seg_ff + AW'(1);
               end
            end
         end
         S_CHECK: begin
            seg_in   = '0;
            start_in = '0;
         end
         S_MOD_DIV: begin
            // A distance that is an exact multiple of the total stays at the
            // total, which lies past the last segment.
            if (u_done) begin
               d_in = (u_rem != '0) ? DW'(u_rem) : DW'(total_ff);
            end
         end
         S_WALK_CAP: begin
            len_in = len_rdata;
            t_in   = walk_diff[BW-1:0];
            if (walk_diff >= DW'(len_rdata)) begin
               start_in = start_ff + TW'(len_rdata);
               if (!last_seg) begin
                  seg_in = seg_ff + AW'(1);
               end
            end
         end
         S_INT_DX: begin
            if (u_done) begin
               pos_x_in = dl_x_ff[C] ? (cur_x_ff - q_low) : (cur_x_ff + q_low);
            end
         end
         S_INT_DY: begin
            if (u_done) begin
               pos_y_in = dl_y_ff[C] ? (cur_y_ff - q_low) : (cur_y_ff + q_low);
            end
         end
         S_INT_DZ: begin
            if (u_done) begin
               pos_z_in = dl_z_ff[C] ? (cur_z_ff - q_low) : (cur_z_ff + q_low);
            end
         end
         default: begin
            seg_in = seg_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         launch_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
         count_ff  <= count_in;
      end
      seg_ff    <= seg_in;
      d_ff      <= d_in;
      total_ff  <= total_in;
      start_ff  <= start_in;
      len_ff    <= len_in;
      t_ff      <= t_in;
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      cur_z_ff  <= cur_z_in;
      dl_x_ff   <= dl_x_in;
      dl_y_ff   <= dl_y_in;
      dl_z_ff   <= dl_z_in;
      pos_x_ff  <= pos_x_in;
      pos_y_ff  <= pos_y_in;
      pos_z_ff  <= pos_z_in;
      status_ff <= status_in;
   end

   pdist_unit #(
      .COORD_WIDTH(COORD_WIDTH),
      .MAX_POINTS (MAX_POINTS)
   ) u_unit (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .opa    (u_opa),
      .opb    (u_opb),
      .divisor(u_divisor),
      .done   (u_done),
      .quot   (u_quot),
      .root   (u_root),
      .rem    (u_rem)
   );

   pdist_store #(
      .COORD_WIDTH(COORD_WIDTH),
      .MAX_POINTS (MAX_POINTS)
   ) u_store (
      .clock    (clock),
      .pt_we    (pt_we),
      .pt_waddr (count_ff[AW-1:0]),
      .wr_x     (req_point_x),
      .wr_y     (req_point_y),
      .wr_z     (req_point_z),
      .pt_raddr (pt_raddr),
      .rd_x     (rd_x),
      .rd_y     (rd_y),
      .rd_z     (rd_z),
      .len_we   (len_we),
      .len_waddr(seg_ff),
      .len_wdata(u_root),
      .len_raddr(seg_ff),
      .len_rdata(len_rdata)
   );

   assign rsp_pos_x  = pos_x_ff;
   assign rsp_pos_y  = pos_y_ff;
   assign rsp_pos_z  = pos_z_ff;
   assign rsp_status = status_ff;

endmodule
`default_nettype wire
